// ===== sv/ic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ic_pkg;

  localparam int unsigned WordWidth  = 16;
  localparam int unsigned SumWidth   = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic NetworkOrderReset = 1'b1;

  // One word ready to be added, and whether it closes the buffer.
  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 ends;
  } ic_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ic_queue_status_t;

  // Two end-around folds of the 32-bit sum, then the complement.
  function automatic logic [WordWidth-1:0] fold_complement(input logic [SumWidth-1:0] s);
    logic [WordWidth:0] first;
    logic [WordWidth:0] second;
    first  = {1'b0, s[SumWidth-1:WordWidth]} + {1'b0, s[WordWidth-1:0]};
    second = first + {{WordWidth{1'b0}}, first[WordWidth]};
    return ~second[WordWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/ic_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ic_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic            cfg_data,
  input  wire logic [7:0]      first_byte,
  input  wire logic [7:0]      second_byte,
  input  wire logic [1:0]      bytes_in_item,
  input  wire logic            last_item,
  output ic_pkg::ic_item_t     item
);

  logic network_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      network_order <= ic_pkg::NetworkOrderReset;
    end else if (cfg_write) begin
      network_order <= cfg_data;
    end
  end

  // A count of two or three carries two bytes; a short item pads with zero
  // and always closes the buffer.
  always_comb begin
    item.word = '0;
    if (bytes_in_item[1]) begin
      item.word = network_order ? {first_byte, second_byte} : {second_byte, first_byte};
    end else if (bytes_in_item[0]) begin
      item.word = network_order ? {first_byte, 8'h00} : {8'h00, first_byte};
    end
    item.ends = last_item || !bytes_in_item[1];
  end

endmodule

`default_nettype wire

// ===== sv/ic_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ic_queue #(
  parameter int unsigned Depth = ic_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ic_pkg::ic_item_t     push_item,
  input  wire logic                 pop,
  output ic_pkg::ic_item_t          head,
  output ic_pkg::ic_queue_status_t  status
);

  localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  ic_pkg::ic_item_t mem [Depth];

  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CountWidth-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == FullCount);
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

// ===== sv/ic_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ic_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 head_valid,
  input  wire ic_pkg::ic_item_t                     head,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [ic_pkg::WordWidth-1:0]              checksum
);

  logic [ic_pkg::SumWidth-1:0] running_sum;
  logic [ic_pkg::SumWidth-1:0] running_sum_next;
  logic [ic_pkg::SumWidth-1:0] final_sum;
  logic                        final_valid;
  logic                        out_free;
  logic                        final_move;
  logic                        final_free;

  assign out_free   = !out_valid || out_ready;
  assign final_move = final_valid && out_free;
  assign final_free = !final_valid || final_move;

  // Words that do not end a buffer never wait on the output side.
  assign pop = head_valid && (!head.ends || final_free);

  assign running_sum_next = running_sum
                          + {{(ic_pkg::SumWidth-ic_pkg::WordWidth){1'b0}}, head.word};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      final_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        running_sum <= head.ends ? '0 : running_sum_next;
      end
      if (pop && head.ends) begin
        final_valid <= 1'b1;
      end else if (final_move) begin
        final_valid <= 1'b0;
      end
      if (final_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.ends) begin
      final_sum <= running_sum_next;
    end
    if (final_move) begin
      checksum <= ic_pkg::fold_complement(final_sum);
    end
  end

endmodule

`default_nettype wire

// ===== sv/internet_checksum.sv =====
// Internet checksum (one's-complement sum of 16-bit words) over a buffer.
// Input channel: one transaction per word, first_byte/second_byte with
// bytes_in_item (0, 1 or 2 valid bytes) and last_item. A transaction with
// fewer than two bytes or with last_item set closes the buffer.
// Output channel: one checksum transaction per buffer.
// cfg_write/cfg_data set the byte order (1: network order, the reset value;
// 0: little-endian native order); write it only while the block is idle.
// Throughput: one input transaction per cycle, sustained while out_ready
// stays high. The accumulator adds one word per cycle; a two-entry queue
// separates word formatting from accumulation, and a final-sum register and
// the output register, which takes the folded sum, follow. A closing
// transaction passes through the queue and both registers in turn.
// When the receiver stalls, the finished checksum and one more wait in the
// back end; words keep flowing until the queue fills and in_ready drops.
// Reset clears the sum, the queue and the output, and restores network order.
`timescale 1ns / 1ps
`default_nettype none

module internet_checksum #(
  parameter int unsigned QueueDepth = ic_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  first_byte,
  input  wire logic [7:0]  second_byte,
  input  wire logic [1:0]  bytes_in_item,
  input  wire logic        last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      checksum
);

  ic_pkg::ic_item_t         front_item;
  ic_pkg::ic_item_t         head;
  ic_pkg::ic_queue_status_t q_status;
  logic                     push;
  logic                     pop;

  ic_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .bytes_in_item(bytes_in_item),
    .last_item    (last_item),
    .item         (front_item)
  );

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  ic_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(front_item),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(!q_status.empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .checksum  (checksum)
  );

`ifndef SYNTH
  // After a word is written into the queue, the queue is not empty on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_status.empty)
    else $error("queue empty right after a push");

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // Reset leaves no stale result and an open input.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output or queue not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/internet_checksum_tb.sv =====
`timescale 1ns / 1ps

module internet_checksum_tb;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] first_byte = 8'h00;
  logic [7:0] second_byte = 8'h00;
  logic [1:0] bytes_in_item = 2'd0;
  logic       last_item = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [15:0] checksum;

  // Predictor state: byte order and the running 32-bit sum.
  logic                        net_order = ic_pkg::NetworkOrderReset;
  logic [ic_pkg::SumWidth-1:0] sum_acc = '0;
  logic [15:0]                 pending_sums[$];
  logic [15:0]                 want_sum;

  // Stall control for both channels.
  bit          tx_throttle = 1'b0;
  bit          rx_throttle = 1'b0;
  int unsigned rx_stall_left = 0;

  int unsigned err_count = 0;
  int unsigned n_words = 0;
  int unsigned n_buffers = 0;
  int unsigned n_checked = 0;
  int unsigned n_order_writes = 0;
  int unsigned count_seen[4] = '{0, 0, 0, 0};

  internet_checksum dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .bytes_in_item(bytes_in_item),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .checksum     (checksum)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Two end-around carries bring the 32-bit sum down to 16 bits.
  function automatic logic [15:0] fold_not(input logic [ic_pkg::SumWidth-1:0] s);
    logic [31:0] t;
    t = {16'h0000, s[31:16]} + {16'h0000, s[15:0]};
    t = t + (t >> 16);
    return ~t[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 20) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic predict_checksum(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [1:0] n, input logic lst);
    logic [15:0] word;
    word = '0;
    if (n >= 2'd2) word = net_order ? {b0, b1} : {b1, b0};
    else if (n == 2'd1) word = net_order ? {b0, 8'h00} : {8'h00, b0};
    sum_acc = sum_acc + {16'h0000, word};
    n_words++;
    count_seen[n]++;
    // A short item closes the buffer whatever last_item says.
    if (lst || n < 2'd2) begin
      pending_sums.push_back(fold_not(sum_acc));
      sum_acc = '0;
      n_buffers++;
    end
  endtask

  task automatic send_word(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [1:0] n, input logic lst);
    int unsigned gap;
    gap = tx_throttle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    first_byte    <= b0;
    second_byte   <= b1;
    bytes_in_item <= n;
    last_item     <= lst;
    do @(posedge clk); while (!in_ready);
    predict_checksum(b0, b1, n, lst);
  endtask

  // Stop sending and wait for every outstanding checksum, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_byte_order(input logic order);
    cfg_write <= 1'b1;
    cfg_data  <= order;
    @(posedge clk);
    cfg_write <= 1'b0;
    net_order = order;
    n_order_writes++;
  endtask

  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("checksum %h arrived with none expected", checksum));
      end else begin
        want_sum = pending_sums.pop_front();
        n_checked++;
        if (checksum !== want_sum)
          report_mismatch($sformatf("checksum %h, expected %h", checksum, want_sum));
      end
    end
  end

  task automatic send_directed_set();
    send_word(8'h00, 8'h00, 2'd0, 1'b1);  // empty buffer
    send_word(8'hFF, 8'hFF, 2'd0, 1'b0);  // empty item without last_item
    send_word(8'hFF, 8'hFF, 2'd2, 1'b1);
    send_word(8'h00, 8'h00, 2'd2, 1'b1);
    send_word(8'h12, 8'h34, 2'd2, 1'b0);
    send_word(8'hAB, 8'hCD, 2'd3, 1'b0);  // byte count three counts as two
    send_word(8'h5A, 8'hFF, 2'd1, 1'b0);  // odd trailing byte closes the buffer
    send_word(8'h80, 8'h01, 2'd2, 1'b0);
    send_word(8'hFF, 8'hA5, 2'd1, 1'b1);
    send_word(8'h01, 8'h80, 2'd3, 1'b1);
  endtask

  task automatic test_directed_cases();
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    send_directed_set();
    drain_results();
    write_byte_order(1'b0);
    send_directed_set();
    drain_results();
    write_byte_order(1'b1);
  endtask

  // A long buffer of all-ones words, so the fold sees large upper halves.
  task automatic test_sum_wrap();
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    repeat (200) send_word(8'hFF, 8'hFF, 2'd2, 1'b0);
    send_word(8'hFF, 8'hFE, 2'd2, 1'b1);
    drain_results();
  endtask

  task automatic test_random_buffers();
    int unsigned words;
    int unsigned len;
    int unsigned sel;
    logic [1:0]  n;
    logic        lst;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      drain_results();
      write_byte_order(phase < 4 ? logic'(phase % 2) : logic'($urandom_range(0, 1)));
      tx_throttle = (phase % 4) != 1;
      rx_throttle = (phase % 4) != 2;
      words = 0;
      while (words < 220) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++) begin
          sel = $urandom_range(0, 99);
          if (i + 1 < len) begin
            // Body words, with a few byte counts of three and a few early breaks.
            if (sel < 4) n = 2'd3;
            else if (sel < 6) n = 2'($urandom_range(0, 1));
            else n = 2'd2;
            lst = (sel == 99);
          end else begin
            case (sel % 5)
              0, 1: begin
                n = 2'd2;
                lst = 1'b1;
              end
              2: begin
                n = 2'd1;
                lst = 1'($urandom_range(0, 1));
              end
              3: begin
                n = 2'd3;
                lst = 1'b1;
              end
              default: begin
                n = 2'd0;
                lst = 1'($urandom_range(0, 1));
              end
            endcase
          end
          send_word(8'($urandom), 8'($urandom), n, lst);
          words++;
        end
        if ($urandom_range(0, 19) == 0) drain_results();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_sum_wrap();
    test_random_buffers();
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d words in %0d buffers (byte counts 0/1/2/3: %0d/%0d/%0d/%0d).",
             n_words, n_buffers, count_seen[0], count_seen[1], count_seen[2],
             count_seen[3]);
    $display("Checked %0d checksums over %0d byte-order writes, including a long buffer.",
             n_checked, n_order_writes);
    if (err_count == 0 && pending_sums.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
